// File: hw/rtl/segx_pkg.sv
// Shared types and constants for the segment intersection pipeline.
package segx_pkg;

   localparam int OUT_BITS = 32;

   typedef logic signed [OUT_BITS-1:0] fixed_type;

   typedef enum logic [1:0] {
      OUTCOME_NONE    = 2'd0,
      OUTCOME_POINT   = 2'd1,
      OUTCOME_OVERLAP = 2'd2
   } outcome_type;

   typedef struct packed {
      outcome_type outcome;
      logic        crossed;
      logic        neg_x;
      logic        neg_y;
   } verdict_type;

endpackage

// File: hw/rtl/segx_req_if.sv
// Request channel: one segment pair per transaction.
interface segx_req_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] first_start_x;
   logic signed [COORD_BITS-1:0] first_start_y;
   logic signed [COORD_BITS-1:0] first_end_x;
   logic signed [COORD_BITS-1:0] first_end_y;
   logic signed [COORD_BITS-1:0] second_start_x;
   logic signed [COORD_BITS-1:0] second_start_y;
   logic signed [COORD_BITS-1:0] second_end_x;
   logic signed [COORD_BITS-1:0] second_end_y;

   modport source (
      output valid, first_start_x, first_start_y, first_end_x, first_end_y,
      output second_start_x, second_start_y, second_end_x, second_end_y,
      input  ready
   );

   modport sink (
      input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
      input  second_start_x, second_start_y, second_end_x, second_end_y,
      output ready
   );
endinterface

// File: hw/rtl/segx_rsp_if.sv
// Response channel: intersection outcome and Q16.16 points per transaction.
interface segx_rsp_if import segx_pkg::*;;
   logic        valid;
   logic        ready;
   outcome_type outcome;
   fixed_type   point_one_x;
   fixed_type   point_one_y;
   fixed_type   point_two_x;
   fixed_type   point_two_y;

   modport source (
      output valid, outcome, point_one_x, point_one_y, point_two_x, point_two_y,
      input  ready
   );

   modport sink (
      input  valid, outcome, point_one_x, point_one_y, point_two_x, point_two_y,
      output ready
   );
endinterface

// File: hw/rtl/segment_intersection.sv
// Throughput: one segment pair per cycle unless the pipeline holds; seven front stages feed a chain of
// COORD_BITS + FRAC_BITS divider cells, one quotient bit per cell, then an output register.
// The pipeline holds only while the output register is full and unread and its last stage is busy.
// Reset is synchronous, active high, and clears only the valid bits; payload is not reset.
module segment_intersection import segx_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input logic        clock,
   input logic        reset,
   segx_req_if.sink   req_bus,
   segx_rsp_if.source rsp_bus
);

   localparam int W      = COORD_BITS;
   localparam int QB     = COORD_BITS + FRAC_BITS;
   localparam int NW     = 3 * COORD_BITS + 3;
   localparam int DB     = 2 * COORD_BITS + 2;
   localparam int DVW    = NW + FRAC_BITS;
   localparam int VB     = $bits(verdict_type);
   localparam int SIDE_W = VB + 4 * COORD_BITS;

   logic                 advance;
   logic                 front_valid;
   verdict_type          front_verdict;
   logic [NW-1:0]        num_x_mag, num_y_mag;
   logic [DB-1:0]        den_mag;
   logic signed [W-1:0]  front_lo_x, front_lo_y, front_hi_x, front_hi_y;
   logic [DVW-1:0]       dividend_x, dividend_y;

   logic                 cell_valid [QB+1];
   logic [DB-1:0]        cell_den   [QB+1];
   logic [DB-1:0]        cell_rem_x [QB+1];
   logic [DB-1:0]        cell_rem_y [QB+1];
   logic [QB-1:0]        cell_dq_x  [QB+1];
   logic [QB-1:0]        cell_dq_y  [QB+1];
   logic [SIDE_W-1:0]    cell_side  [QB+1];

   verdict_type          last_verdict;
   logic signed [W-1:0]  last_lo_x, last_lo_y, last_hi_x, last_hi_y;
   logic signed [QB:0]   div_x, div_y;
   logic signed [QB-1:0] lo_x_sc, lo_y_sc, hi_x_sc, hi_y_sc;
   logic                 load;

   logic                 rsp_valid_in;
   outcome_type          outcome_in;
   fixed_type            p1x_in, p1y_in, p2x_in, p2y_in;
   logic                 rsp_valid_ff;
   outcome_type          outcome_ff;
   fixed_type            p1x_ff, p1y_ff, p2x_ff, p2y_ff;

   assign advance       = !cell_valid[QB] || !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   segx_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_bus.valid),
      .ax        (req_bus.first_start_x),
      .ay        (req_bus.first_start_y),
      .bx        (req_bus.first_end_x),
      .by        (req_bus.first_end_y),
      .cx        (req_bus.second_start_x),
      .cy        (req_bus.second_start_y),
      .dx        (req_bus.second_end_x),
      .dy        (req_bus.second_end_y),
      .out_valid (front_valid),
      .verdict   (front_verdict),
      .num_x_mag (num_x_mag),
      .num_y_mag (num_y_mag),
      .den_mag   (den_mag),
      .lo_x      (front_lo_x),
      .lo_y      (front_lo_y),
      .hi_x      (front_hi_x),
      .hi_y      (front_hi_y)
   );

   // dividend = |num| * 2^FRAC_BITS; top part seeds the remainder, low QB bits shift in
   assign dividend_x = DVW'(num_x_mag) << FRAC_BITS;
   assign dividend_y = DVW'(num_y_mag) << FRAC_BITS;

   assign cell_valid[0] = front_valid;
   assign cell_den[0]   = den_mag;
   assign cell_rem_x[0] = DB'(dividend_x >> QB);
   assign cell_rem_y[0] = DB'(dividend_y >> QB);
   assign cell_dq_x[0]  = dividend_x[QB-1:0];
   assign cell_dq_y[0]  = dividend_y[QB-1:0];
   assign cell_side[0]  = {front_verdict, front_lo_x, front_lo_y, front_hi_x, front_hi_y};

   for (genvar i = 0; i < QB; i++) begin : g_cell
      segx_div_cell #(
         .DEN_BITS  (DB),
         .QUO_BITS  (QB),
         .SIDE_BITS (SIDE_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .valid_i (cell_valid[i]),
         .den_i   (cell_den[i]),
         .rem_x_i (cell_rem_x[i]),
         .dq_x_i  (cell_dq_x[i]),
         .rem_y_i (cell_rem_y[i]),
         .dq_y_i  (cell_dq_y[i]),
         .side_i  (cell_side[i]),
         .valid_o (cell_valid[i+1]),
         .den_o   (cell_den[i+1]),
         .rem_x_o (cell_rem_x[i+1]),
         .dq_x_o  (cell_dq_x[i+1]),
         .rem_y_o (cell_rem_y[i+1]),
         .dq_y_o  (cell_dq_y[i+1]),
         .side_o  (cell_side[i+1])
      );
   end

   assign {last_verdict, last_lo_x, last_lo_y, last_hi_x, last_hi_y} = cell_side[QB];

   always_comb begin
      div_x   = last_verdict.neg_x ? -$signed({1'b0, cell_dq_x[QB]}) : $signed({1'b0, cell_dq_x[QB]});
      div_y   = last_verdict.neg_y ? -$signed({1'b0, cell_dq_y[QB]}) : $signed({1'b0, cell_dq_y[QB]});
      lo_x_sc = QB'(last_lo_x) <<< FRAC_BITS;
      lo_y_sc = QB'(last_lo_y) <<< FRAC_BITS;
      hi_x_sc = QB'(last_hi_x) <<< FRAC_BITS;
      hi_y_sc = QB'(last_hi_y) <<< FRAC_BITS;
      outcome_in = last_verdict.outcome;
      p1x_in  = last_verdict.crossed ? OUT_BITS'(div_x) : OUT_BITS'(lo_x_sc);
      p1y_in  = last_verdict.crossed ? OUT_BITS'(div_y) : OUT_BITS'(lo_y_sc);
      p2x_in  = OUT_BITS'(hi_x_sc);
      p2y_in  = OUT_BITS'(hi_y_sc);
      load    = cell_valid[QB] && (!rsp_valid_ff || rsp_bus.ready);
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         outcome_ff <= outcome_in;
         p1x_ff     <= p1x_in;
         p1y_ff     <= p1y_in;
         p2x_ff     <= p2x_in;
         p2y_ff     <= p2y_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.outcome     = outcome_ff;
   assign rsp_bus.point_one_x = p1x_ff;
   assign rsp_bus.point_one_y = p1y_ff;
   assign rsp_bus.point_two_x = p2x_ff;
   assign rsp_bus.point_two_y = p2y_ff;

endmodule

// File: hw/rtl/segx_front.sv
// Front pipeline: bounding box, cross products, classification, numerators.
module segx_front import segx_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] ax,
   input  logic signed [COORD_BITS-1:0] ay,
   input  logic signed [COORD_BITS-1:0] bx,
   input  logic signed [COORD_BITS-1:0] by,
   input  logic signed [COORD_BITS-1:0] cx,
   input  logic signed [COORD_BITS-1:0] cy,
   input  logic signed [COORD_BITS-1:0] dx,
   input  logic signed [COORD_BITS-1:0] dy,
   output logic                         out_valid,
   output verdict_type                  verdict,
   output logic [3*COORD_BITS+2:0]      num_x_mag,
   output logic [3*COORD_BITS+2:0]      num_y_mag,
   output logic [2*COORD_BITS+1:0]      den_mag,
   output logic signed [COORD_BITS-1:0] lo_x,
   output logic signed [COORD_BITS-1:0] lo_y,
   output logic signed [COORD_BITS-1:0] hi_x,
   output logic signed [COORD_BITS-1:0] hi_y
);

   localparam int W   = COORD_BITS;
   localparam int DW  = W + 1;
   localparam int PW  = 2 * W + 2;
   localparam int XW  = 2 * W + 3;
   localparam int SPL = W + 2;
   localparam int HW  = XW - SPL;
   localparam int LPW = DW + SPL + 1;
   localparam int HPW = DW + HW;
   localparam int NW  = 3 * W + 3;
   localparam int DB  = 2 * W + 2;
   localparam int NSTAGE = 7;

   function automatic logic lex_less(input logic signed [W-1:0] ux, input logic signed [W-1:0] uy,
                                     input logic signed [W-1:0] vx, input logic signed [W-1:0] vy);
      return (ux < vx) || ((ux == vx) && (uy < vy));
   endfunction

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;

   // stage 1: differences, bounding box, per-segment endpoint order
   logic signed [W-1:0]  ab_max_x, ab_min_x, ab_max_y, ab_min_y;
   logic signed [W-1:0]  cd_max_x, cd_min_x, cd_max_y, cd_min_y;
   logic                 reject_in;
   logic                 swap_ab, swap_cd;
   logic signed [DW-1:0] abx_s1_ff, aby_s1_ff, cdx_s1_ff, cdy_s1_ff;
   logic signed [DW-1:0] acx_s1_ff, acy_s1_ff, adx_s1_ff, ady_s1_ff, cbx_s1_ff, cby_s1_ff;
   logic signed [W-1:0]  ax_s1_ff, ay_s1_ff;
   logic signed [W-1:0]  p1x_s1_ff, p1y_s1_ff, q1x_s1_ff, q1y_s1_ff;
   logic signed [W-1:0]  p2x_s1_ff, p2y_s1_ff, q2x_s1_ff, q2y_s1_ff;
   logic                 reject_s1_ff;

   // stage 2: products, shared span of a collinear overlap
   logic signed [PW-1:0] m1a_s2_ff, m1b_s2_ff, m2a_s2_ff, m2b_s2_ff, m3a_s2_ff, m3b_s2_ff;
   logic signed [PW-1:0] m4a_s2_ff, m4b_s2_ff, mda_s2_ff, mdb_s2_ff, mna_s2_ff, mnb_s2_ff;
   logic signed [W-1:0]  lox_s2_ff, loy_s2_ff, hix_s2_ff, hiy_s2_ff;
   logic signed [W-1:0]  ax_s2_ff, ay_s2_ff;
   logic signed [DW-1:0] abx_s2_ff, aby_s2_ff;
   logic                 reject_s2_ff;

   // stage 3: cross products and determinants
   logic signed [XW-1:0] d1_s3_ff, d2_s3_ff, d3_s3_ff, d4_s3_ff, den_s3_ff, n_s3_ff;
   logic signed [W-1:0]  lox_s3_ff, loy_s3_ff, hix_s3_ff, hiy_s3_ff;
   logic signed [W-1:0]  ax_s3_ff, ay_s3_ff;
   logic signed [DW-1:0] abx_s3_ff, aby_s3_ff;
   logic                 reject_s3_ff, empty_s3_ff, equal_s3_ff;

   // stage 4: classification, split numerator products
   logic                 d1z, d2z, d3z, d4z, all_zero, degen, same12, same34;
   verdict_type          verdict_s4_in;
   logic signed [W-1:0]  lox_s4_in, loy_s4_in, hix_s4_in, hiy_s4_in;
   logic signed [HW-1:0] den_hi, n_hi;
   logic signed [LPW-1:0] den_lo, n_lo;
   verdict_type          verdict_s4_ff;
   logic signed [W-1:0]  lox_s4_ff, loy_s4_ff, hix_s4_ff, hiy_s4_ff;
   logic signed [LPW-1:0] axd_lo_s4_ff, ayd_lo_s4_ff, abn_lo_s4_ff, aybn_lo_s4_ff;
   logic signed [HPW-1:0] axd_hi_s4_ff, ayd_hi_s4_ff, abn_hi_s4_ff, aybn_hi_s4_ff;
   logic signed [XW-1:0] den_s4_ff;

   // stage 5: partial sums
   verdict_type          verdict_s5_ff;
   logic signed [W-1:0]  lox_s5_ff, loy_s5_ff, hix_s5_ff, hiy_s5_ff;
   logic signed [NW-1:0] pax_s5_ff, pbx_s5_ff, pay_s5_ff, pby_s5_ff;
   logic signed [XW-1:0] den_s5_ff;

   // stage 6: numerators
   verdict_type          verdict_s6_ff;
   logic signed [W-1:0]  lox_s6_ff, loy_s6_ff, hix_s6_ff, hiy_s6_ff;
   logic signed [NW-1:0] numx_s6_ff, numy_s6_ff;
   logic signed [XW-1:0] den_s6_ff;

   // stage 7: magnitudes and quotient signs
   verdict_type          verdict_s7_in;
   verdict_type          verdict_s7_ff;
   logic signed [W-1:0]  lox_s7_ff, loy_s7_ff, hix_s7_ff, hiy_s7_ff;
   logic [NW-1:0]        numx_s7_ff, numy_s7_ff;
   logic [DB-1:0]        den_s7_ff;

   assign valid_in = {valid_ff[NSTAGE-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      ab_max_x = (ax > bx) ? ax : bx;
      ab_min_x = (ax > bx) ? bx : ax;
      ab_max_y = (ay > by) ? ay : by;
      ab_min_y = (ay > by) ? by : ay;
      cd_max_x = (cx > dx) ? cx : dx;
      cd_min_x = (cx > dx) ? dx : cx;
      cd_max_y = (cy > dy) ? cy : dy;
      cd_min_y = (cy > dy) ? dy : cy;
      reject_in = (ab_max_x < cd_min_x) || (cd_max_x < ab_min_x) ||
                  (ab_max_y < cd_min_y) || (cd_max_y < ab_min_y);
      swap_ab = lex_less(bx, by, ax, ay);
      swap_cd = lex_less(dx, dy, cx, cy);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         abx_s1_ff    <= DW'(bx) - DW'(ax);
         aby_s1_ff    <= DW'(by) - DW'(ay);
         cdx_s1_ff    <= DW'(dx) - DW'(cx);
         cdy_s1_ff    <= DW'(dy) - DW'(cy);
         acx_s1_ff    <= DW'(cx) - DW'(ax);
         acy_s1_ff    <= DW'(cy) - DW'(ay);
         adx_s1_ff    <= DW'(dx) - DW'(ax);
         ady_s1_ff    <= DW'(dy) - DW'(ay);
         cbx_s1_ff    <= DW'(bx) - DW'(cx);
         cby_s1_ff    <= DW'(by) - DW'(cy);
         ax_s1_ff     <= ax;
         ay_s1_ff     <= ay;
         reject_s1_ff <= reject_in;
         p1x_s1_ff    <= swap_ab ? bx : ax;
         p1y_s1_ff    <= swap_ab ? by : ay;
         q1x_s1_ff    <= swap_ab ? ax : bx;
         q1y_s1_ff    <= swap_ab ? ay : by;
         p2x_s1_ff    <= swap_cd ? dx : cx;
         p2y_s1_ff    <= swap_cd ? dy : cy;
         q2x_s1_ff    <= swap_cd ? cx : dx;
         q2y_s1_ff    <= swap_cd ? cy : dy;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m1a_s2_ff <= PW'(abx_s1_ff) * PW'(acy_s1_ff);
         m1b_s2_ff <= PW'(aby_s1_ff) * PW'(acx_s1_ff);
         m2a_s2_ff <= PW'(abx_s1_ff) * PW'(ady_s1_ff);
         m2b_s2_ff <= PW'(aby_s1_ff) * PW'(adx_s1_ff);
         m3a_s2_ff <= PW'(cdy_s1_ff) * PW'(acx_s1_ff);
         m3b_s2_ff <= PW'(cdx_s1_ff) * PW'(acy_s1_ff);
         m4a_s2_ff <= PW'(cdx_s1_ff) * PW'(cby_s1_ff);
         m4b_s2_ff <= PW'(cdy_s1_ff) * PW'(cbx_s1_ff);
         mda_s2_ff <= PW'(abx_s1_ff) * PW'(cdy_s1_ff);
         mdb_s2_ff <= PW'(aby_s1_ff) * PW'(cdx_s1_ff);
         mna_s2_ff <= PW'(acx_s1_ff) * PW'(cdy_s1_ff);
         mnb_s2_ff <= PW'(acy_s1_ff) * PW'(cdx_s1_ff);
         if (lex_less(p1x_s1_ff, p1y_s1_ff, p2x_s1_ff, p2y_s1_ff)) begin
            lox_s2_ff <= p2x_s1_ff;
            loy_s2_ff <= p2y_s1_ff;
         end else begin
            lox_s2_ff <= p1x_s1_ff;
            loy_s2_ff <= p1y_s1_ff;
         end
         if (lex_less(q1x_s1_ff, q1y_s1_ff, q2x_s1_ff, q2y_s1_ff)) begin
            hix_s2_ff <= q1x_s1_ff;
            hiy_s2_ff <= q1y_s1_ff;
         end else begin
            hix_s2_ff <= q2x_s1_ff;
            hiy_s2_ff <= q2y_s1_ff;
         end
         ax_s2_ff     <= ax_s1_ff;
         ay_s2_ff     <= ay_s1_ff;
         abx_s2_ff    <= abx_s1_ff;
         aby_s2_ff    <= aby_s1_ff;
         reject_s2_ff <= reject_s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d1_s3_ff     <= XW'(m1a_s2_ff) - XW'(m1b_s2_ff);
         d2_s3_ff     <= XW'(m2a_s2_ff) - XW'(m2b_s2_ff);
         d3_s3_ff     <= XW'(m3a_s2_ff) - XW'(m3b_s2_ff);
         d4_s3_ff     <= XW'(m4a_s2_ff) - XW'(m4b_s2_ff);
         den_s3_ff    <= XW'(mda_s2_ff) - XW'(mdb_s2_ff);
         n_s3_ff      <= XW'(mna_s2_ff) - XW'(mnb_s2_ff);
         empty_s3_ff  <= lex_less(hix_s2_ff, hiy_s2_ff, lox_s2_ff, loy_s2_ff);
         equal_s3_ff  <= (hix_s2_ff == lox_s2_ff) && (hiy_s2_ff == loy_s2_ff);
         lox_s3_ff    <= lox_s2_ff;
         loy_s3_ff    <= loy_s2_ff;
         hix_s3_ff    <= hix_s2_ff;
         hiy_s3_ff    <= hiy_s2_ff;
         ax_s3_ff     <= ax_s2_ff;
         ay_s3_ff     <= ay_s2_ff;
         abx_s3_ff    <= abx_s2_ff;
         aby_s3_ff    <= aby_s2_ff;
         reject_s3_ff <= reject_s2_ff;
      end
   end

   always_comb begin
      d1z      = (d1_s3_ff == '0);
      d2z      = (d2_s3_ff == '0);
      d3z      = (d3_s3_ff == '0);
      d4z      = (d4_s3_ff == '0);
      all_zero = d1z && d2z && d3z && d4z;
      degen    = (d1z && d2z) || (d3z && d4z);
      same12   = !d1z && !d2z && (d1_s3_ff[XW-1] == d2_s3_ff[XW-1]);
      same34   = !d3z && !d4z && (d3_s3_ff[XW-1] == d4_s3_ff[XW-1]);
      den_hi   = den_s3_ff[XW-1:SPL];
      n_hi     = n_s3_ff[XW-1:SPL];
      den_lo   = LPW'($signed({1'b0, den_s3_ff[SPL-1:0]}));
      n_lo     = LPW'($signed({1'b0, n_s3_ff[SPL-1:0]}));

      verdict_s4_in.outcome = OUTCOME_NONE;
      verdict_s4_in.crossed = 1'b0;
      verdict_s4_in.neg_x   = 1'b0;
      verdict_s4_in.neg_y   = 1'b0;
      lox_s4_in = '0;
      loy_s4_in = '0;
      hix_s4_in = '0;
      hiy_s4_in = '0;
      if (!reject_s3_ff && all_zero && !empty_s3_ff) begin
         lox_s4_in = lox_s3_ff;
         loy_s4_in = loy_s3_ff;
         if (equal_s3_ff) begin
            verdict_s4_in.outcome = OUTCOME_POINT;
         end else begin
            verdict_s4_in.outcome = OUTCOME_OVERLAP;
            hix_s4_in = hix_s3_ff;
            hiy_s4_in = hiy_s3_ff;
         end
      end else if (!reject_s3_ff && !all_zero && !degen && !same12 && !same34 &&
                   (den_s3_ff != '0)) begin
         verdict_s4_in.outcome = OUTCOME_POINT;
         verdict_s4_in.crossed = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         verdict_s4_ff <= verdict_s4_in;
         lox_s4_ff     <= lox_s4_in;
         loy_s4_ff     <= loy_s4_in;
         hix_s4_ff     <= hix_s4_in;
         hiy_s4_ff     <= hiy_s4_in;
         axd_lo_s4_ff  <= LPW'(ax_s3_ff) * den_lo;
         axd_hi_s4_ff  <= HPW'(ax_s3_ff) * HPW'(den_hi);
         ayd_lo_s4_ff  <= LPW'(ay_s3_ff) * den_lo;
         ayd_hi_s4_ff  <= HPW'(ay_s3_ff) * HPW'(den_hi);
         abn_lo_s4_ff  <= LPW'(abx_s3_ff) * n_lo;
         abn_hi_s4_ff  <= HPW'(abx_s3_ff) * HPW'(n_hi);
         aybn_lo_s4_ff <= LPW'(aby_s3_ff) * n_lo;
         aybn_hi_s4_ff <= HPW'(aby_s3_ff) * HPW'(n_hi);
         den_s4_ff     <= den_s3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         verdict_s5_ff <= verdict_s4_ff;
         lox_s5_ff     <= lox_s4_ff;
         loy_s5_ff     <= loy_s4_ff;
         hix_s5_ff     <= hix_s4_ff;
         hiy_s5_ff     <= hiy_s4_ff;
         pax_s5_ff     <= (NW'(axd_hi_s4_ff) <<< SPL) + NW'(axd_lo_s4_ff);
         pbx_s5_ff     <= (NW'(abn_hi_s4_ff) <<< SPL) + NW'(abn_lo_s4_ff);
         pay_s5_ff     <= (NW'(ayd_hi_s4_ff) <<< SPL) + NW'(ayd_lo_s4_ff);
         pby_s5_ff     <= (NW'(aybn_hi_s4_ff) <<< SPL) + NW'(aybn_lo_s4_ff);
         den_s5_ff     <= den_s4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         verdict_s6_ff <= verdict_s5_ff;
         lox_s6_ff     <= lox_s5_ff;
         loy_s6_ff     <= loy_s5_ff;
         hix_s6_ff     <= hix_s5_ff;
         hiy_s6_ff     <= hiy_s5_ff;
         numx_s6_ff    <= pax_s5_ff + pbx_s5_ff;
         numy_s6_ff    <= pay_s5_ff + pby_s5_ff;
         den_s6_ff     <= den_s5_ff;
      end
   end

   always_comb begin
      verdict_s7_in       = verdict_s6_ff;
      verdict_s7_in.neg_x = numx_s6_ff[NW-1] ^ den_s6_ff[XW-1];
      verdict_s7_in.neg_y = numy_s6_ff[NW-1] ^ den_s6_ff[XW-1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         verdict_s7_ff <= verdict_s7_in;
         lox_s7_ff     <= lox_s6_ff;
         loy_s7_ff     <= loy_s6_ff;
         hix_s7_ff     <= hix_s6_ff;
         hiy_s7_ff     <= hiy_s6_ff;
         numx_s7_ff    <= numx_s6_ff[NW-1] ? NW'(-numx_s6_ff) : NW'(numx_s6_ff);
         numy_s7_ff    <= numy_s6_ff[NW-1] ? NW'(-numy_s6_ff) : NW'(numy_s6_ff);
         den_s7_ff     <= den_s6_ff[XW-1] ? DB'(-den_s6_ff) : DB'(den_s6_ff);
      end
   end

   assign out_valid = valid_ff[NSTAGE-1];
   assign verdict   = verdict_s7_ff;
   assign num_x_mag = numx_s7_ff;
   assign num_y_mag = numy_s7_ff;
   assign den_mag   = den_s7_ff;
   assign lo_x      = lox_s7_ff;
   assign lo_y      = loy_s7_ff;
   assign hi_x      = hix_s7_ff;
   assign hi_y      = hiy_s7_ff;

endmodule

// File: hw/rtl/segx_div_cell.sv
// Divider cell: one restoring quotient bit for the x and y lanes, sideband carried along.
module segx_div_cell #(
   parameter int DEN_BITS  = 34,
   parameter int QUO_BITS  = 32,
   parameter int SIDE_BITS = 69
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 valid_i,
   input  logic [DEN_BITS-1:0]  den_i,
   input  logic [DEN_BITS-1:0]  rem_x_i,
   input  logic [QUO_BITS-1:0]  dq_x_i,
   input  logic [DEN_BITS-1:0]  rem_y_i,
   input  logic [QUO_BITS-1:0]  dq_y_i,
   input  logic [SIDE_BITS-1:0] side_i,
   output logic                 valid_o,
   output logic [DEN_BITS-1:0]  den_o,
   output logic [DEN_BITS-1:0]  rem_x_o,
   output logic [QUO_BITS-1:0]  dq_x_o,
   output logic [DEN_BITS-1:0]  rem_y_o,
   output logic [QUO_BITS-1:0]  dq_y_o,
   output logic [SIDE_BITS-1:0] side_o
);

   logic [DEN_BITS:0]    trial_x, trial_y;
   logic [DEN_BITS+1:0]  diff_x, diff_y;
   logic                 borrow_x, borrow_y;
   logic [DEN_BITS-1:0]  rem_x_in, rem_y_in;
   logic [QUO_BITS-1:0]  dq_x_in, dq_y_in;

   logic                 valid_ff;
   logic [DEN_BITS-1:0]  den_ff, rem_x_ff, rem_y_ff;
   logic [QUO_BITS-1:0]  dq_x_ff, dq_y_ff;
   logic [SIDE_BITS-1:0] side_ff;

   // dq shifts dividend bits out at the top and quotient bits in at the bottom
   always_comb begin
      trial_x  = {rem_x_i, dq_x_i[QUO_BITS-1]};
      trial_y  = {rem_y_i, dq_y_i[QUO_BITS-1]};
      diff_x   = {1'b0, trial_x} - {2'b00, den_i};
      diff_y   = {1'b0, trial_y} - {2'b00, den_i};
      borrow_x = diff_x[DEN_BITS+1];
      borrow_y = diff_y[DEN_BITS+1];
      rem_x_in = borrow_x ? trial_x[DEN_BITS-1:0] : diff_x[DEN_BITS-1:0];
      rem_y_in = borrow_y ? trial_y[DEN_BITS-1:0] : diff_y[DEN_BITS-1:0];
      dq_x_in  = {dq_x_i[QUO_BITS-2:0], ~borrow_x};
      dq_y_in  = {dq_y_i[QUO_BITS-2:0], ~borrow_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff   <= den_i;
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         dq_x_ff  <= dq_x_in;
         dq_y_ff  <= dq_y_in;
         side_ff  <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign den_o   = den_ff;
   assign rem_x_o = rem_x_ff;
   assign rem_y_o = rem_y_ff;
   assign dq_x_o  = dq_x_ff;
   assign dq_y_o  = dq_y_ff;
   assign side_o  = side_ff;

endmodule
